// ----- src/bfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and defaults for the backface cull and erase bounds block.
// ----------------------------------------------------------------------------
package bfc_pkg;

    // default screen size
    localparam int SCREEN_W_DEF = 320;
    localparam int SCREEN_H_DEF = 240;

    // input word
    typedef struct packed {
        logic               command;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               last_vertex;
        logic        [7:0]  face_color;
    } t_in_word;

    // output word
    typedef struct packed {
        logic       face_visible;
        logic [7:0] color_out;
        logic [8:0] rect_left;
        logic [7:0] rect_top;
        logic [8:0] rect_right;
        logic [7:0] rect_bottom;
    } t_out_word;

    // command codes
    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // extent of a face including its current vertex
    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
    } t_extent;

    // control of the erase rectangle store
    typedef struct packed {
        logic clear;
        logic update;
        logic page;
    } t_rect_ctl;

    // erase rectangle at output field widths
    typedef struct packed {
        logic [8:0] left;
        logic [7:0] top;
        logic [8:0] right;
        logic [7:0] bottom;
    } t_rect;

endpackage

// ----- src/bfc_face.sv -----
// ----------------------------------------------------------------------------
// bfc_face
// Face gathering: first and second vertex, vertex count, running extent,
// and the cross product sign at the last vertex.
// ----------------------------------------------------------------------------
module bfc_face (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic               i_last,
    output logic               o_visible,
    output bfc_pkg::t_extent   o_extent
);

    localparam logic [1:0] CNT_MAX = 2'd3;

    logic signed [15:0] r_first_x, r_first_y;
    logic signed [15:0] r_second_x, r_second_y;
    logic        [1:0]  r_count;
    bfc_pkg::t_extent   r_ext;
    bfc_pkg::t_extent   n_ext;
    bfc_pkg::t_extent   ext_rst;

    logic signed [16:0] v1, v2, w1, w2;
    logic signed [33:0] p1, p2;
    logic signed [34:0] cross_prod;

    // empty extent
    always_comb begin
        ext_rst.min_x = 16'sh7FFF;
        ext_rst.min_y = 16'sh7FFF;
        ext_rst.max_x = -16'sh8000;
        ext_rst.max_y = -16'sh8000;
    end

    // extent widened by the current vertex
    always_comb begin
        n_ext.min_x = (i_x < r_ext.min_x) ? i_x : r_ext.min_x;
        n_ext.max_x = (i_x > r_ext.max_x) ? i_x : r_ext.max_x;
        n_ext.min_y = (i_y < r_ext.min_y) ? i_y : r_ext.min_y;
        n_ext.max_y = (i_y > r_ext.max_y) ? i_y : r_ext.max_y;
    end

    assign o_extent = n_ext;

    // cross product (v1 - v0) x (vlast - v0)
    assign v1         = {r_second_x[15], r_second_x} - {r_first_x[15], r_first_x};
    assign v2         = {r_second_y[15], r_second_y} - {r_first_y[15], r_first_y};
    assign w1         = {i_x[15], i_x} - {r_first_x[15], r_first_x};
    assign w2         = {i_y[15], i_y} - {r_first_y[15], r_first_y};
    assign p1         = v1 * w2;
    assign p2         = v2 * w1;
    assign cross_prod = {p1[33], p1} - {p2[33], p2};

    // at least three vertices once this one is counted
    assign o_visible = r_count[1] && !cross_prod[34] && (cross_prod != '0);

    // count and extent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ext   <= ext_rst;
        end else if (i_step) begin
            if (i_last) begin
                r_count <= '0;
                r_ext   <= ext_rst;
            end else begin
                if (r_count != CNT_MAX) begin
                    r_count <= r_count + 2'd1;
                end
                r_ext <= n_ext;
            end
        end
    end

    // stored vertices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_second_x <= '0;
            r_second_y <= '0;
        end else if (i_step) begin
            if (r_count == 2'd0) begin
                r_first_x <= i_x;
                r_first_y <= i_y;
            end else if (r_count == 2'd1) begin
                r_second_x <= i_x;
                r_second_y <= i_y;
            end
        end
    end

endmodule

// ----- src/bfc_rect.sv -----
// ----------------------------------------------------------------------------
// bfc_rect
// Erase rectangles of both display pages: widen to a visible face's
// extent with clamping to the screen, or clear on command.
// ----------------------------------------------------------------------------
module bfc_rect #(
    parameter int SCREEN_W = bfc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = bfc_pkg::SCREEN_H_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfc_pkg::t_rect_ctl  i_ctl,
    input  bfc_pkg::t_extent    i_ext,
    output bfc_pkg::t_rect      o_rect
);

    localparam int XW        = $clog2(SCREEN_W + 1);
    localparam int YW        = $clog2(SCREEN_H + 1);
    localparam int NUM_PAGES = 2;

    localparam logic [XW-1:0]   W_U = XW'(SCREEN_W);
    localparam logic [YW-1:0]   H_U = YW'(SCREEN_H);
    localparam logic signed [16:0] W_S = 17'(SCREEN_W);
    localparam logic signed [16:0] H_S = 17'(SCREEN_H);
    localparam logic signed [16:0] ZERO_S = 17'sd0;

    logic [XW-1:0] r_left   [NUM_PAGES];
    logic [YW-1:0] r_top    [NUM_PAGES];
    logic [XW-1:0] r_right  [NUM_PAGES];
    logic [YW-1:0] r_bottom [NUM_PAGES];

    logic [XW-1:0] n_left, n_right;
    logic [YW-1:0] n_top, n_bottom;

    logic signed [16:0] left_s, top_s, right_s, bottom_s;
    logic signed [16:0] min_x_s, max_x_s, min_y_s, max_y_s;
    logic signed [16:0] cl_left, cl_top, cl_right, cl_bottom;

    // selected page edges as signed values
    assign left_s   = 17'(r_left[i_ctl.page]);
    assign top_s    = 17'(r_top[i_ctl.page]);
    assign right_s  = 17'(r_right[i_ctl.page]);
    assign bottom_s = 17'(r_bottom[i_ctl.page]);

    assign min_x_s = {i_ext.min_x[15], i_ext.min_x};
    assign max_x_s = {i_ext.max_x[15], i_ext.max_x};
    assign min_y_s = {i_ext.min_y[15], i_ext.min_y};
    assign max_y_s = {i_ext.max_y[15], i_ext.max_y};

    // clamp extent to the screen
    assign cl_left   = (min_x_s > ZERO_S) ? min_x_s : ZERO_S;
    assign cl_top    = (min_y_s > ZERO_S) ? min_y_s : ZERO_S;
    assign cl_right  = (max_x_s < W_S) ? max_x_s : W_S;
    assign cl_bottom = (max_y_s < H_S) ? max_y_s : H_S;

    // page edges after this word
    always_comb begin
        n_left   = r_left[i_ctl.page];
        n_top    = r_top[i_ctl.page];
        n_right  = r_right[i_ctl.page];
        n_bottom = r_bottom[i_ctl.page];
        if (i_ctl.update) begin
            if (min_x_s < left_s)   n_left   = XW'(cl_left);
            if (min_y_s < top_s)    n_top    = YW'(cl_top);
            if (max_x_s > right_s)  n_right  = XW'(cl_right);
            if (max_y_s > bottom_s) n_bottom = YW'(cl_bottom);
        end
    end

    // masked to the output field widths
    assign o_rect.left   = 9'(n_left);
    assign o_rect.top    = 8'(n_top);
    assign o_rect.right  = 9'(n_right);
    assign o_rect.bottom = 8'(n_bottom);

    // page storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PAGES; k++) begin
                r_left[k]   <= W_U;
                r_top[k]    <= H_U;
                r_right[k]  <= '0;
                r_bottom[k] <= '0;
            end
        end else if (i_ctl.clear) begin
            r_left[i_ctl.page]   <= W_U;
            r_top[i_ctl.page]    <= H_U;
            r_right[i_ctl.page]  <= '0;
            r_bottom[i_ctl.page] <= '0;
        end else if (i_ctl.update) begin
            r_left[i_ctl.page]   <= n_left;
            r_top[i_ctl.page]    <= n_top;
            r_right[i_ctl.page]  <= n_right;
            r_bottom[i_ctl.page] <= n_bottom;
        end
    end

endmodule

// ----- src/backface_cull_erase_bounds_core.sv -----
// ----------------------------------------------------------------------------
// backface_cull_erase_bounds_core
// Backface culling by screen-space cross product with per-page erase bounds.
// ----------------------------------------------------------------------------
// Vertex words enter one per cycle unless a last-vertex word meets a full
// result register and low i_out_ready. A last-vertex word produces one
// result word (input register, then result register) with visibility,
// color and the target page's erase rectangle after the update. The single
// compute stage between the two registers forms the two 17x17 products of
// the cross product and the extent compare and clamp. A clear word empties
// the target page's rectangle and produces no result. Faces with fewer than
// three vertices are not visible. The user must write the page register
// through i_cfg_we only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module backface_cull_erase_bounds_core #(
    parameter int SCREEN_W = bfc_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = bfc_pkg::SCREEN_H_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfc_pkg::t_out_word  o_out_word
);

    logic                r_page;
    logic                r_in_valid;
    bfc_pkg::t_in_word   r_in;
    logic                r_out_valid;
    bfc_pkg::t_out_word  r_out;
    bfc_pkg::t_out_word  n_out;

    logic                has_result;
    logic                advance;
    logic                face_step;
    logic                visible;
    bfc_pkg::t_extent    extent;
    bfc_pkg::t_rect_ctl  rect_ctl;
    bfc_pkg::t_rect      rect;

    // handshake control
    assign has_result = (r_in.command == bfc_pkg::CMD_VERTEX) && r_in.last_vertex;
    assign advance    = r_in_valid && (!has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign face_step  = advance && (r_in.command == bfc_pkg::CMD_VERTEX);

    // face gathering and visibility
    bfc_face u_face (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (face_step),
        .i_x       (r_in.vertex_x),
        .i_y       (r_in.vertex_y),
        .i_last    (r_in.last_vertex),
        .o_visible (visible),
        .o_extent  (extent)
    );

    // erase rectangle control
    always_comb begin
        rect_ctl.clear  = advance && (r_in.command == bfc_pkg::CMD_CLEAR);
        rect_ctl.update = face_step && r_in.last_vertex && visible;
        rect_ctl.page   = r_page;
    end

    bfc_rect #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_rect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rect_ctl),
        .i_ext   (extent),
        .o_rect  (rect)
    );

    // result word
    always_comb begin
        n_out.face_visible = visible;
        n_out.color_out    = r_in.face_color;
        n_out.rect_left    = rect.left;
        n_out.rect_top     = rect.top;
        n_out.rect_right   = rect.right;
        n_out.rect_bottom  = rect.bottom;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_page <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (advance && has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
